/* rtl/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes of the free page bitmap allocator: transfer
// payloads, request opcodes and controller state encodings.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // fixed field widths of the request and result transfers
    localparam int IDX_W = 10;

    // request opcodes
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_TOGGLE = 1'b1;

    // request transfer
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] page_index;
    } fpba_in_t;

    // result transfer
    typedef struct packed {
        logic [IDX_W-1:0] found_page;
        logic             map_full;
        logic             bit_now;
    } fpba_out_t;

    // main controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_SCAN,
        ST_TOG_RD,
        ST_TOG_WR,
        ST_DONE
    } fpba_state_t;

    // index unit states
    typedef enum logic [2:0] {
        IX_IDLE,
        IX_MOD_Q,
        IX_MOD_R,
        IX_DIV_Q,
        IX_DIV_R
    } ix_state_t;

endpackage

/* rtl/free_page_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// free_page_bitmap_allocator_top
// Next-fit free page allocator over a one-bit-per-page usage map in RAM.
//
//   s_ channel carries requests: op find returns the first free page at or
//   above the hint (wrapping), without marking it; op toggle flips the used
//   bit of a page and returns its new value. m_ channel carries one result
//   per request, in order.
//   After reset the map RAM is cleared one word per cycle, all MAP_WORDS
//   words (32 by default), with s_ready low; every page then reads as free.
//   One request is processed at a time. A find runs four index steps, a
//   handoff, then one map word read per cycle from the RAM's single read
//   port, each evaluated in the cycle after its read. A toggle runs two
//   index steps, then read-modify-write of one word. A toggle of a page
//   beyond the map skips the index steps and the map access. s_ready rises
//   again together with m_valid, when the result enters the output register.
//   Results sit in an output register; a new request is accepted while a
//   result waits, and a finished result holds until m_ready frees the
//   register.
// ----------------------------------------------------------------------------
module free_page_bitmap_allocator_top #(
    parameter int NUM_PAGES     = 1024,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fpba_pkg::fpba_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output fpba_pkg::fpba_out_t m_payload
);

    import fpba_pkg::*;

    localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int NW        = $clog2(MAP_WORDS + 2);

    localparam logic [WORD_W-1:0] LAST_WORD  = WORD_W'(MAP_WORDS - 1);
    localparam logic [NW-1:0]     FINAL_N    = NW'(MAP_WORDS);
    localparam logic [PAGE_W-1:0] WORD_STEP  = PAGE_W'(MAP_WORD_BITS);

    fpba_state_t         state_reg, state_next;
    logic                op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    fpba_out_t           res_reg, res_next;
    logic [WORD_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [WORD_W-1:0]   tw_reg, tw_next;
    logic [BIT_W-1:0]    tb_reg, tb_next;

    // scan issue stage
    logic [WORD_W-1:0]   iss_w_reg, iss_w_next;
    logic [PAGE_W-1:0]   iss_base_reg, iss_base_next;
    logic [NW-1:0]       iss_n_reg, iss_n_next;
    logic [BIT_W-1:0]    b0_reg, b0_next;

    // scan evaluate stage
    logic                ev_valid_reg, ev_valid_next;
    logic                ev_first_reg, ev_first_next;
    logic                ev_final_reg, ev_final_next;
    logic                ev_last_reg, ev_last_next;
    logic [PAGE_W-1:0]   ev_base_reg, ev_base_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    fpba_out_t           m_payload_reg;
    logic                out_load;

    // index unit
    logic                ix_start;
    logic                ix_done;
    logic [PAGE_W-1:0]   ix_page;
    logic [WORD_W-1:0]   ix_word;
    logic [BIT_W-1:0]    ix_bit;

    // map RAM
    logic                ram_we;
    logic [WORD_W-1:0]   ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [WORD_W-1:0]   ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic                srch_found;
    logic [BIT_W-1:0]    srch_pos;
    logic [MAP_WORD_BITS-1:0] toggled_word;
    logic                issuing;
    logic                out_of_range;

    fpba_index_div #(
        .NUM_PAGES     (NUM_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .MAP_WORDS     (MAP_WORDS),
        .PAGE_W        (PAGE_W),
        .WORD_W        (WORD_W),
        .BIT_W         (BIT_W)
    ) u_index (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ix_start),
        .do_mod  (s_payload.op == OP_FIND),
        .idx     (s_payload.page_index),
        .done    (ix_done),
        .page    (ix_page),
        .word    (ix_word),
        .bit_pos (ix_bit)
    );

    fpba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WORD_W)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpba_word_search #(
        .NUM_PAGES     (NUM_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .BIT_W         (BIT_W)
    ) u_search (
        .word_data  (ram_rdata),
        .last_word  (ev_last_reg),
        .first_pass (ev_first_reg),
        .final_pass (ev_final_reg),
        .start_bit  (b0_reg),
        .found      (srch_found),
        .bit_pos    (srch_pos)
    );

    // helpers
    assign toggled_word = ram_rdata ^ (MAP_WORD_BITS'(1'b1) << tb_reg);
    assign issuing      = iss_n_reg <= FINAL_N;
    assign out_of_range = 32'(s_payload.page_index) >= 32'(NUM_PAGES);
    assign ram_raddr    = (state_reg == ST_SCAN) ? iss_w_reg : tw_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            ev_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            ev_valid_reg <= ev_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        res_reg      <= res_next;
        tw_reg       <= tw_next;
        tb_reg       <= tb_next;
        iss_w_reg    <= iss_w_next;
        iss_base_reg <= iss_base_next;
        iss_n_reg    <= iss_n_next;
        b0_reg       <= b0_next;
        ev_first_reg <= ev_first_next;
        ev_final_reg <= ev_final_next;
        ev_last_reg  <= ev_last_next;
        ev_base_reg  <= ev_base_next;
        if (out_load) begin
            m_payload_reg <= res_reg;
        end
    end

    // next state and datapath control
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        clr_cnt_next  = clr_cnt_reg;
        tw_next       = tw_reg;
        tb_next       = tb_reg;
        iss_w_next    = iss_w_reg;
        iss_base_next = iss_base_reg;
        iss_n_next    = iss_n_reg;
        b0_next       = b0_reg;
        ev_valid_next = 1'b0;
        ev_first_next = ev_first_reg;
        ev_final_next = ev_final_reg;
        ev_last_next  = ev_last_reg;
        ev_base_next  = ev_base_reg;
        ix_start      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = tw_reg;
        ram_wdata     = toggled_word;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_payload.op;
                    idx_next = s_payload.page_index;
                    if ((s_payload.op == OP_TOGGLE) && out_of_range) begin
                        res_next.found_page = s_payload.page_index;
                        res_next.map_full   = 1'b0;
                        res_next.bit_now    = 1'b0;
                        state_next          = ST_DONE;
                    end else begin
                        ix_start   = 1'b1;
                        state_next = ST_INDEX;
                    end
                end
            end
            ST_INDEX: begin
                if (ix_done) begin
                    if (op_reg == OP_FIND) begin
                        iss_w_next    = ix_word;
                        iss_base_next = ix_page - PAGE_W'(ix_bit);
                        b0_next       = ix_bit;
                        iss_n_next    = '0;
                        state_next    = ST_SCAN;
                    end else begin
                        tw_next    = ix_word;
                        tb_next    = ix_bit;
                        state_next = ST_TOG_RD;
                    end
                end
            end
            ST_SCAN: begin
                // issue one word read per cycle
                ev_valid_next = issuing;
                ev_first_next = iss_n_reg == '0;
                ev_final_next = iss_n_reg == FINAL_N;
                ev_last_next  = iss_w_reg == LAST_WORD;
                ev_base_next  = iss_base_reg;
                if (issuing) begin
                    iss_n_next = iss_n_reg + 1'b1;
                    if (iss_w_reg == LAST_WORD) begin
                        iss_w_next    = '0;
                        iss_base_next = '0;
                    end else begin
                        iss_w_next    = iss_w_reg + 1'b1;
                        iss_base_next = iss_base_reg + WORD_STEP;
                    end
                end
                // evaluate the word read in the previous cycle
                if (ev_valid_reg && srch_found) begin
                    res_next.found_page = IDX_W'(ev_base_reg + PAGE_W'(srch_pos));
                    res_next.map_full   = 1'b0;
                    res_next.bit_now    = 1'b0;
                    ev_valid_next       = 1'b0;
                    state_next          = ST_DONE;
                end else if (ev_valid_reg && ev_final_reg) begin
                    res_next.found_page = '0;
                    res_next.map_full   = 1'b1;
                    res_next.bit_now    = 1'b0;
                    ev_valid_next       = 1'b0;
                    state_next          = ST_DONE;
                end
            end
            ST_TOG_RD: begin
                state_next = ST_TOG_WR;
            end
            ST_TOG_WR: begin
                ram_we              = 1'b1;
                res_next.found_page = idx_reg;
                res_next.map_full   = 1'b0;
                res_next.bit_now    = toggled_word[tb_reg];
                state_next          = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // one request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    // a full-map result carries page 0 and no used bit
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.map_full |-> m_payload.found_page == '0 && !m_payload.bit_now)
        else $error("full result with nonzero page or bit");

    // index unit completes only when the controller waits for it
    a_index_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ix_done |-> state_reg == ST_INDEX)
        else $error("index unit done outside index wait");

    // scan word pointer stays inside the map
    a_scan_word: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> iss_w_reg <= LAST_WORD)
        else $error("scan word pointer beyond map");

    // map writes happen only during clearing or the toggle write-back
    a_map_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == ST_CLEAR || state_reg == ST_TOG_WR)
        else $error("unexpected map write");

endmodule

/* rtl/fpba_ram.sv */
// ----------------------------------------------------------------------------
// fpba_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fpba_index_div.sv */
// ----------------------------------------------------------------------------
// fpba_index_div
// Splits a page index into map word and bit position by reciprocal
// multiplication, after an optional reduction modulo the page count.
// Four steps with the reduction, two without.
// ----------------------------------------------------------------------------
module fpba_index_div #(
    parameter int NUM_PAGES     = 1024,
    parameter int MAP_WORD_BITS = 32,
    parameter int MAP_WORDS     = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    parameter int PAGE_W        = $clog2(NUM_PAGES),
    parameter int WORD_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    parameter int BIT_W         = $clog2(MAP_WORD_BITS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     do_mod,
    input  logic [fpba_pkg::IDX_W-1:0] idx,
    output logic                     done,
    output logic [PAGE_W-1:0]        page,
    output logic [WORD_W-1:0]        word,
    output logic [BIT_W-1:0]         bit_pos
);

    import fpba_pkg::*;

    // floor(x / d) == (x * ceil(2^(n+l) / d)) >> (n+l) for any n-bit x,
    // with l = clog2(d)
    localparam int MOD_SH = IDX_W + PAGE_W;
    localparam int MOD_PW = 2 * IDX_W + 2;
    localparam int DIV_SH = PAGE_W + BIT_W;
    localparam int DIV_PW = 2 * PAGE_W + 2;

    localparam logic [MOD_PW-1:0] MOD_M =
        MOD_PW'(((64'd1 << MOD_SH) + 64'(NUM_PAGES) - 64'd1) / 64'(NUM_PAGES));
    localparam logic [DIV_PW-1:0] DIV_M =
        DIV_PW'(((64'd1 << DIV_SH) + 64'(MAP_WORD_BITS) - 64'd1) / 64'(MAP_WORD_BITS));
    localparam logic [MOD_PW-1:0] MOD_D = MOD_PW'(NUM_PAGES);
    localparam logic [DIV_PW-1:0] DIV_D = DIV_PW'(MAP_WORD_BITS);

    ix_state_t         state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  mq_reg, mq_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              done_reg, done_next;

    logic [MOD_PW-1:0] mod_prod;
    logic [MOD_PW-1:0] mod_quo;
    logic [MOD_PW-1:0] mod_rem;
    logic [DIV_PW-1:0] div_prod;
    logic [DIV_PW-1:0] div_quo;
    logic [DIV_PW-1:0] div_rem;

    // hint reduction: quotient, then remainder a step later
    assign mod_prod = MOD_PW'(idx_reg) * MOD_M;
    assign mod_quo  = mod_prod >> MOD_SH;
    assign mod_rem  = MOD_PW'(idx_reg) - MOD_PW'(mq_reg) * MOD_D;

    // word and bit split of the page
    assign div_prod = DIV_PW'(page_reg) * DIV_M;
    assign div_quo  = div_prod >> DIV_SH;
    assign div_rem  = DIV_PW'(page_reg) - DIV_PW'(word_reg) * DIV_D;

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IX_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        mq_reg   <= mq_next;
        page_reg <= page_next;
        word_reg <= word_next;
        bit_reg  <= bit_next;
    end

    // step sequencing
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mq_next    = mq_reg;
        page_next  = page_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            IX_IDLE: begin
                if (start) begin
                    idx_next  = idx;
                    page_next = PAGE_W'(idx);
                    if (do_mod) begin
                        state_next = IX_MOD_Q;
                    end else begin
                        state_next = IX_DIV_Q;
                    end
                end
            end
            IX_MOD_Q: begin
                mq_next    = IDX_W'(mod_quo);
                state_next = IX_MOD_R;
            end
            IX_MOD_R: begin
                page_next  = PAGE_W'(mod_rem);
                state_next = IX_DIV_Q;
            end
            IX_DIV_Q: begin
                word_next  = WORD_W'(div_quo);
                state_next = IX_DIV_R;
            end
            IX_DIV_R: begin
                bit_next   = BIT_W'(div_rem);
                done_next  = 1'b1;
                state_next = IX_IDLE;
            end
            default: begin
                state_next = IX_IDLE;
            end
        endcase
    end

    assign done    = done_reg;
    assign page    = page_reg;
    assign word    = word_reg;
    assign bit_pos = bit_reg;

endmodule

/* rtl/fpba_word_search.sv */
// ----------------------------------------------------------------------------
// fpba_word_search
// Masks one map word to the pages that the current scan pass may consider
// and returns the lowest free bit with a priority encoder.
// ----------------------------------------------------------------------------
module fpba_word_search #(
    parameter int NUM_PAGES     = 1024,
    parameter int MAP_WORD_BITS = 32,
    parameter int BIT_W         = $clog2(MAP_WORD_BITS)
) (
    input  logic [MAP_WORD_BITS-1:0] word_data,
    input  logic                     last_word,
    input  logic                     first_pass,
    input  logic                     final_pass,
    input  logic [BIT_W-1:0]         start_bit,
    output logic                     found,
    output logic [BIT_W-1:0]         bit_pos
);

    localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int LAST_BITS = NUM_PAGES - (MAP_WORDS - 1) * MAP_WORD_BITS;

    logic [MAP_WORD_BITS-1:0] mask;
    logic [MAP_WORD_BITS-1:0] free_bits;

    // pages eligible in this pass: inside the map, and on the right side
    // of the start bit when the start word is visited
    always_comb begin
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            mask[i] = 1'b1;
            if (last_word && (i >= LAST_BITS)) begin
                mask[i] = 1'b0;
            end
            if (first_pass && (BIT_W'(i) < start_bit)) begin
                mask[i] = 1'b0;
            end
            if (final_pass && (BIT_W'(i) >= start_bit)) begin
                mask[i] = 1'b0;
            end
        end
    end

    assign free_bits = ~word_data & mask;
    assign found     = |free_bits;

    // lowest free bit
    always_comb begin
        bit_pos = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                bit_pos = BIT_W'(i);
            end
        end
    end

endmodule
